// File: rtl/integer_to_ascii_formatter_assert.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define ITA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ITA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Types, constants and helpers shared by the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

   // Opcodes
   localparam logic [2:0] OP_SDEC  = 3'd0;
   localparam logic [2:0] OP_UDEC  = 3'd1;
   localparam logic [2:0] OP_HEXL  = 3'd2;
   localparam logic [2:0] OP_HEXU  = 3'd3;
   localparam logic [2:0] OP_PTR   = 3'd4;

   localparam int DABBLE_STEPS = 32;
   localparam int BCD_DIGITS   = 10;
   localparam logic [4:0] DEC_WINDOW   = 5'd10;
   localparam logic [4:0] HEX32_WINDOW = 5'd8;
   localparam logic [4:0] HEX64_WINDOW = 5'd16;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [4:0] char_count;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic skip;
      logic emit_sign;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bit_last;
      logic top_zero;
      logic left_one;
      logic neg;
   } status_type;

   function automatic logic [7:0] nibble_to_ascii(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      begin
         base = upper ? 8'h37 : 8'h57;
         nibble_to_ascii = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (base + {4'd0, nib});
      end
   endfunction

endpackage

// File: rtl/ita_datapath.sv
// ----------------------------------------------------------------------------
// ita_datapath
// Double-dabble converter, digit window and result register.
// ----------------------------------------------------------------------------
module ita_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ita_pkg::req_type  req_data,
   input  ita_pkg::cmd_type  cmd,
   output ita_pkg::status_type status,
   output logic              rsp_valid,
   output ita_pkg::rsp_type  rsp_data
);
   import ita_pkg::*;

   logic [63:0] digits_ff, digits_in;
   logic [31:0] bin_ff, bin_in;
   logic [4:0]  left_ff, left_in;
   logic [4:0]  count_ff, count_in;
   logic [4:0]  bitcnt_ff, bitcnt_in;
   logic        upper_ff, upper_in;
   logic        neg_ff, neg_in;
   logic        valid_ff, valid_in;
   rsp_type     word_ff, word_in;

   logic [39:0] bcd_adj;
   logic [31:0] low_word;
   logic [4:0]  count_inc;

   assign low_word  = req_data.value[31:0];
   assign count_inc = count_ff + 5'd1;

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (digits_ff[24 + i*4 +: 4] >= 4'd5) ?
                             digits_ff[24 + i*4 +: 4] + 4'd3 : digits_ff[24 + i*4 +: 4];
      end
   end

   always_comb begin
      digits_in = digits_ff;
      bin_in    = bin_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      bitcnt_in = bitcnt_ff;
      upper_in  = upper_ff;
      neg_in    = neg_ff;
      valid_in  = 1'b0;
      word_in   = word_ff;
      if (cmd.load) begin
         count_in  = 5'd0;
         bitcnt_in = 5'd0;
         upper_in  = (req_data.opcode == OP_HEXU);
         neg_in    = (req_data.opcode == OP_SDEC) && low_word[31];
         bin_in    = ((req_data.opcode == OP_SDEC) && low_word[31]) ? (~low_word + 32'd1)
                                                                     : low_word;
         if (req_data.opcode == OP_PTR) begin
            digits_in = req_data.value;
            left_in   = HEX64_WINDOW;
         end else if ((req_data.opcode == OP_HEXL) || (req_data.opcode == OP_HEXU)) begin
            digits_in = {low_word, 32'd0};
            left_in   = HEX32_WINDOW;
         end else begin
            digits_in = 64'd0;
            left_in   = DEC_WINDOW;
         end
      end
      if (cmd.dabble) begin
         digits_in = {bcd_adj[38:0], bin_ff[31], 24'd0};
         bin_in    = {bin_ff[30:0], 1'b0};
         bitcnt_in = bitcnt_ff + 5'd1;
      end
      if (cmd.skip || cmd.emit) begin
         digits_in = {digits_ff[59:0], 4'd0};
         left_in   = left_ff - 5'd1;
      end
      if (cmd.emit_sign) begin
         valid_in           = 1'b1;
         count_in           = count_inc;
         word_in.char_code  = CHAR_MINUS;
         word_in.char_count = count_inc;
         word_in.last       = 1'b0;
      end
      if (cmd.emit) begin
         valid_in           = 1'b1;
         count_in           = count_inc;
         word_in.char_code  = nibble_to_ascii(digits_ff[63:60], upper_ff);
         word_in.char_count = count_inc;
         word_in.last       = (left_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      digits_ff <= digits_in;
      bin_ff    <= bin_in;
      left_ff   <= left_in;
      count_ff  <= count_in;
      bitcnt_ff <= bitcnt_in;
      upper_ff  <= upper_in;
      neg_ff    <= neg_in;
      word_ff   <= word_in;
   end

   assign status.bit_last = (bitcnt_ff == 5'(DABBLE_STEPS - 1));
   assign status.top_zero = (digits_ff[63:60] == 4'd0);
   assign status.left_one = (left_ff == 5'd1);
   assign status.neg      = neg_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_data        = word_ff;

`include "integer_to_ascii_formatter_assert.svh"
   `ITA_ASSERT_NXT(a_last_ends_burst, rsp_valid && rsp_data.last, !rsp_valid, "word after last")
   `ITA_ASSERT_IMP(a_count_range, rsp_valid, (rsp_data.char_count != 5'd0) && (rsp_data.char_count <= 5'd16), "char_count out of range")
   `ITA_ASSERT_IMP(a_emit_has_digit, cmd.emit || cmd.skip, left_ff != 5'd0, "digit window empty")

endmodule

// File: rtl/ita_controller.sv
// ----------------------------------------------------------------------------
// ita_controller
// Sequences load, BCD conversion, leading-zero skip, sign and digit output.
// ----------------------------------------------------------------------------
module ita_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          opcode,
   input  ita_pkg::status_type status,
   output ita_pkg::cmd_type    cmd,
   output logic                busy
);
   import ita_pkg::*;

   state_type state_ff, state_in;
   logic      op_ok;
   logic      op_dec;

   assign op_ok  = (opcode == OP_SDEC) || (opcode == OP_UDEC) || (opcode == OP_HEXL) ||
                   (opcode == OP_HEXU) || (opcode == OP_PTR);
   assign op_dec = (opcode == OP_SDEC) || (opcode == OP_UDEC);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && op_ok) begin
               state_in = op_dec ? ST_CONVERT : ST_SKIP;
            end
         end
         ST_CONVERT: begin
            if (status.bit_last) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!status.top_zero || status.left_one) begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.left_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
         end
         ST_SKIP: begin
            cmd.skip = status.top_zero && !status.left_one;
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "integer_to_ascii_formatter_assert.svh"
   `ITA_ASSERT_NXT(a_emit_done, (state_ff == ST_EMIT) && status.left_one, state_ff == ST_IDLE, "emit did not finish")
   `ITA_ASSERT_IMP(a_sign_only_neg, cmd.emit_sign, status.neg, "sign on non-negative value")
   `ITA_ASSERT_NXT(a_convert_done, (state_ff == ST_CONVERT) && status.bit_last, state_ff == ST_SKIP, "conversion overran")

endmodule

// File: rtl/integer_to_ascii_formatter.sv
// Sequence, start to last word: decimal runs the 32 BCD steps, then walks the digit window
//   (leading zeros skipped, then sign if negative, then digits) into the result register;
//   hex skips the BCD steps and walks an 8-digit (32-bit) or 16-digit (64-bit) window.
// Back to back: a new start is taken in the cycle the last word is on rsp_data, not before;
//   unused opcodes are taken from idle and emit nothing.
// Results cannot be stalled; reset is synchronous, active high, and returns to idle.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 32- or 64-bit integer as decimal or hex ASCII, one character per
// word, most significant digit first, with running count and last flag.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ita_pkg::req_type req_data,
   output logic             rsp_valid,
   output ita_pkg::rsp_type rsp_data
);
   import ita_pkg::*;

   // Command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // Sequencer: accept the request, run the 32 BCD shift steps for decimal
   // opcodes, drop leading zero digits, then issue the sign and the digits.
   // Unused opcodes are accepted and produce no word.
   ita_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Datapath: digit window with the top digit always in the upper nibble,
   // BCD converter working in the upper 40 bits, and the result register.
   ita_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter bench
// Sends opcode/value words through the start/busy handshake, predicts the
// character stream for each accepted word and checks every strobed result
// word, field by field and in order, against that prediction.
// ----------------------------------------------------------------------------
module testbench;
   import ita_pkg::*;

   // Character stream predictor and checker. Each accepted request word
   // expands into one expected result word per character.
   class ascii_scoreboard;
      rsp_type     pending_chars[$];
      int unsigned error_count;

      // Format one request word and queue its characters, most significant first.
      function void push_formatted(req_type item);
         logic [63:0] mag;
         logic [31:0] low_mag;
         logic [4:0]  base;
         logic [3:0]  nib;
         logic        upper;
         logic        neg;
         logic [7:0]  digits[16];
         int          n;
         int          k;
         rsp_type     w;
         mag   = {32'd0, item.value[31:0]};
         base  = 5'd10;
         upper = 1'b0;
         neg   = 1'b0;
         case (item.opcode)
            OP_SDEC: begin
               // Negative: minus sign, then the two's-complement magnitude.
               if (item.value[31]) begin
                  neg     = 1'b1;
                  low_mag = ~item.value[31:0] + 32'd1;
                  mag     = {32'd0, low_mag};
               end
            end
            OP_UDEC: ;
            OP_HEXL: base = 5'd16;
            OP_HEXU: begin
               base  = 5'd16;
               upper = 1'b1;
            end
            OP_PTR: begin
               base = 5'd16;
               mag  = item.value;
            end
            default: return;   // unused opcodes produce nothing
         endcase
         n = 0;
         do begin
            nib       = 4'(mag % base);
            digits[n] = (nib < 4'd10) ? 8'("0") + 8'(nib)
                                      : (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
            n++;
            mag = mag / base;
         end while (mag != 64'd0 && n < 16);
         k = 0;
         if (neg) begin
            k            = 1;
            w.char_code  = CHAR_MINUS;
            w.char_count = 5'd1;
            w.last       = 1'b0;
            pending_chars.push_back(w);
         end
         for (int i = n - 1; i >= 0; i--) begin
            k++;
            w.char_code  = digits[i];
            w.char_count = 5'(k);
            w.last       = (i == 0);
            pending_chars.push_back(w);
         end
      endfunction

      // Compare one result word with the oldest queued character.
      function void check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual %h", $time, got);
            error_count++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.char_code !== want.char_code) begin
            $display("%0t: char_code: expected %h, actual %h", $time,
                     want.char_code, got.char_code);
            error_count++;
         end
         if (got.char_count !== want.char_count) begin
            $display("%0t: char_count: expected %0d, actual %0d", $time,
                     want.char_count, got.char_count);
            error_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last: expected %b, actual %b", $time, want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   ascii_scoreboard char_board = new();
   int unsigned     formatted_sent;

   integer_to_ascii_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watch both channels at every rising edge. Values read here are the ones
   // that held before the edge, so acceptance matches what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            char_board.push_formatted(req_data);
         end
         if (rsp_valid) begin
            char_board.check_char(rsp_data);
         end
      end
   end

   // Present one word and hold it until the block takes it. Leave start high
   // so a following word can go out back to back.
   task automatic send_word(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (item.opcode <= OP_PTR) begin
         formatted_sent++;
      end
   endtask

   // Drop start and idle for a number of cycles.
   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and hold off until every queued character has come back.
   task automatic drain_chars();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (char_board.pending_chars.size() != 0);
   endtask

   function automatic req_type make_word(input logic [2:0] op, input logic [63:0] val);
      req_type w;
      w.opcode = op;
      w.value  = val;
      return w;
   endfunction

   // Random request word: mostly legal opcodes, a little noise, and values
   // shaped to hit every digit length as well as the sign boundary.
   function automatic req_type random_word();
      logic [63:0] val;
      logic [2:0]  op;
      if ($urandom_range(0, 15) == 0) begin
         op = OP_PTR + 3'($urandom_range(1, 3));
      end else begin
         op = 3'($urandom_range(OP_SDEC, OP_PTR));
      end
      val = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;                                             // full width
         1: val = val >> $urandom_range(0, 63);           // random length
         2: val = {val[63:32], 32'($urandom_range(0, 20))};
         default: val = {val[63:32], 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2};
      endcase
      return make_word(op, val);
   endfunction

   initial begin
      req_type directed_words[$];
      int unsigned burst;

      // Known values on every input from time zero.
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      formatted_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero and extremes in every notation, the most negative
      // signed value, upper bits that must be ignored, and unused opcodes.
      directed_words = '{
         make_word(OP_SDEC, 64'd0),
         make_word(OP_SDEC, 64'h0000_0000_7FFF_FFFF),
         make_word(OP_SDEC, 64'h0000_0000_8000_0000),
         make_word(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF),
         make_word(OP_SDEC, 64'hDEAD_BEEF_0000_0005),
         make_word(OP_UDEC, 64'd0),
         make_word(OP_UDEC, 64'h0000_0000_FFFF_FFFF),
         make_word(OP_UDEC, 64'd1000000000),
         make_word(OP_UDEC, 64'hFFFF_FFFF_0000_0009),
         make_word(OP_HEXL, 64'd0),
         make_word(OP_HEXL, 64'h0000_0000_DEAD_BEEF),
         make_word(OP_HEXL, 64'h1234_5678_FFFF_FFFF),
         make_word(OP_HEXU, 64'd0),
         make_word(OP_HEXU, 64'h0000_0000_ABCD_EF01),
         make_word(OP_HEXU, 64'hFFFF_FFFF_FFFF_FFFF),
         make_word(OP_PTR,  64'd0),
         make_word(OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF),
         make_word(OP_PTR,  64'h0000_0001_0000_0000),
         make_word(OP_PTR,  64'h0123_4567_89AB_CDEF),
         make_word(OP_PTR + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF),
         make_word(OP_PTR + 3'd2, 64'd0),
         make_word(OP_PTR + 3'd3, 64'h5555_5555_AAAA_AAAA),
         make_word(OP_SDEC, 64'd1)
      };
      foreach (directed_words[i]) begin
         send_word(directed_words[i]);
      end
      drain_chars();
      formatted_sent = 0;

      // Random: bursts of back-to-back words separated by gaps that land on
      // every phase of the conversion. Drain once mid-run.
      while (formatted_sent < 250) begin
         burst = $urandom_range(1, 16);
         repeat (burst) send_word(random_word());
         if (formatted_sent >= 125 && formatted_sent < 125 + burst) begin
            drain_chars();
         end else if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 60));
         end
      end

      // Wait for the last characters, then a latency's worth of quiet to
      // catch anything extra.
      drain_chars();
      repeat (60) @(posedge clock);
      if (char_board.error_count == 0 && char_board.pending_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
